/* sv/als_pkg.sv */
// shared types and constants for the arming link supervisor
package als_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_THROTTLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 2'd2;

	localparam logic [15:0] MAX_THROTTLE_RST = 16'd1000;
	localparam logic [7:0] SELECT_MAX_RST = 8'd5;
	localparam logic [15:0] LINK_TIMEOUT_RST = 16'd250;

	typedef enum logic [1:0] {
		CMD_PACKET = 2'd0,
		CMD_TICK = 2'd1,
		CMD_CRC = 2'd2,
		CMD_MALFORMED = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [31:0] now_ms;
		logic [15:0] sid;
		logic [15:0] sequence_req;
		logic arm_cmd;
		logic estop;
		logic [15:0] throttle;
		logic [7:0] aux_select;
		logic [7:0] aux_reserved;
		logic driver_ok;
	} in_item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [8:0] error_bits;
		logic [15:0] applied_level;
		logic [15:0] requested_level;
		logic outputs_active;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		in_item_t item;
		logic pkt_bad;
		logic thr_zero;
		logic over_max;
	} cls_item_t;

	// front to back handshake
	typedef struct packed {
		logic valid;
		cls_item_t head;
	} front_out_t;

endpackage

/* sv/als_front.sv */
// front end: accepts items, classifies them and queues them for the back end
module als_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input als_pkg::in_item_t in_item,
	input logic [15:0] max_throttle,
	input logic [7:0] select_max,
	input logic deq,
	output als_pkg::front_out_t front_out
);

	als_pkg::cls_item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic enq;
	logic deq_ok;
	als_pkg::cls_item_t cls;

	// packet checks that depend only on the item and the configuration
	always_comb begin
		cls.item = in_item;
		cls.pkt_bad = (in_item.aux_select > select_max) || (in_item.aux_reserved != 8'd0);
		cls.thr_zero = (in_item.throttle == 16'd0);
		cls.over_max = (in_item.throttle > max_throttle);
	end

	assign full = (cnt_q == 2'd2);
	assign enq = push && !full;
	assign deq_ok = deq && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq_ok) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq_ok})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign front_out.valid = (cnt_q != 2'd0);
	assign front_out.head = mem_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("front queue count out of range");

	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !deq |=> cnt_q == 2'd2)
		else $error("front queue lost an entry while full");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		deq && front_out.valid |=> cnt_q <= 2'd2)
		else $error("front queue underflow");

endmodule

/* sv/als_back.sv */
// back end: supervisor state update and result queue
module als_back (
	input logic clk,
	input logic arst_n,
	input als_pkg::front_out_t front_out,
	output logic deq,
	input logic [15:0] max_throttle,
	input logic [15:0] link_timeout_ms,
	output logic empty,
	input logic pop,
	output als_pkg::out_item_t out_item
);

	typedef enum logic [1:0] {
		MODE_DISARMED = 2'd0,
		MODE_ARMED = 2'd1,
		MODE_FAILSAFE = 2'd2,
		MODE_ERROR = 2'd3
	} mode_t;

	localparam int E_INV = 0;
	localparam int E_CRC = 1;
	localparam int E_SEQ = 2;
	localparam int E_SESS = 3;
	localparam int E_LINK = 4;
	localparam int E_FS = 5;
	localparam int E_ARMREJ = 6;
	localparam int E_CLAMP = 7;
	localparam int E_PWM = 8;

	mode_t mode_q, n_mode;
	logic [8:0] err_q, n_err;
	logic [15:0] sess_q, n_sess;
	logic sess_known_q, n_sess_known;
	logic [15:0] seq_q, n_seq;
	logic seq_known_q, n_seq_known;
	logic need_q, n_need;
	logic [31:0] lvt_q, n_lvt;
	logic link_q, n_link;
	logic [15:0] applied_q, n_applied;
	logic [15:0] requested_q, n_requested;
	logic [7:0] sel_q, n_sel;

	als_pkg::out_item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop_ok;
	als_pkg::out_item_t res;
	als_pkg::in_item_t it;

	logic sess_new;
	logic seq_known_eff;
	logic [15:0] seq_diff;
	logic seq_newer;
	logic [31:0] elapsed;
	logic arm_go;

	assign deq = front_out.valid && (cnt_q != 2'd2);
	assign pop_ok = pop && (cnt_q != 2'd0);
	assign it = front_out.head.item;

	always_comb begin
		n_mode = mode_q;
		n_err = err_q;
		n_sess = sess_q;
		n_sess_known = sess_known_q;
		n_seq = seq_q;
		n_seq_known = seq_known_q;
		n_need = need_q;
		n_lvt = lvt_q;
		n_link = link_q;
		n_applied = applied_q;
		n_requested = requested_q;
		n_sel = sel_q;
		sess_new = !sess_known_q || (it.sid != sess_q);
		seq_known_eff = sess_new ? 1'b0 : seq_known_q;
		seq_diff = it.sequence_req - seq_q;
		seq_newer = (seq_diff != 16'd0) && !seq_diff[15];
		elapsed = it.now_ms - lvt_q;
		arm_go = 1'b0;
		unique case (als_pkg::cmd_t'(it.command))
			als_pkg::CMD_PACKET: begin
				if (front_out.head.pkt_bad) begin
					n_err[E_INV] = 1'b1;
					n_applied = 16'd0;
				end else if (mode_q == MODE_ARMED && it.aux_select != sel_q
						&& !front_out.head.thr_zero) begin
					// selection change under throttle
					n_applied = 16'd0;
					n_need = 1'b1;
					n_mode = MODE_FAILSAFE;
					n_err[E_INV] = 1'b1;
					n_err[E_FS] = 1'b1;
				end else begin
					if (sess_new) begin
						n_applied = 16'd0;
						n_sess = it.sid;
						n_sess_known = 1'b1;
						n_seq_known = 1'b0;
						n_need = 1'b1;
						n_err[E_SESS] = 1'b1;
						if (mode_q != MODE_ERROR) begin
							n_mode = MODE_DISARMED;
						end
					end
					if (seq_known_eff && !seq_newer) begin
						n_err[E_SEQ] = 1'b1;
					end else begin
						n_seq_known = 1'b1;
						n_seq = it.sequence_req;
						n_lvt = it.now_ms;
						n_link = 1'b1;
						n_err[E_LINK] = 1'b0;
						n_requested = it.throttle;
						n_sel = it.aux_select;
						if (n_mode == MODE_ERROR) begin
							n_applied = 16'd0;
						end else if (it.estop) begin
							n_applied = 16'd0;
							n_need = 1'b1;
							n_mode = MODE_FAILSAFE;
							n_err[E_FS] = 1'b1;
						end else if (!it.arm_cmd) begin
							n_applied = 16'd0;
							n_mode = MODE_DISARMED;
							if (front_out.head.thr_zero) begin
								n_need = 1'b0;
								n_err[E_FS] = 1'b0;
								n_err[E_ARMREJ] = 1'b0;
							end
						end else if (n_mode == MODE_FAILSAFE || n_need) begin
							n_err[E_ARMREJ] = 1'b1;
							n_applied = 16'd0;
						end else begin
							arm_go = 1'b1;
							if (n_mode == MODE_DISARMED) begin
								// arming needs zero throttle and a healthy driver
								if (!front_out.head.thr_zero) begin
									n_err[E_ARMREJ] = 1'b1;
									arm_go = 1'b0;
								end else if (!it.driver_ok) begin
									n_mode = MODE_ERROR;
									n_err[E_PWM] = 1'b1;
									arm_go = 1'b0;
								end else begin
									n_mode = MODE_ARMED;
								end
							end
							if (arm_go) begin
								if (front_out.head.over_max) begin
									n_applied = max_throttle;
									n_err[E_CLAMP] = 1'b1;
								end else begin
									n_applied = it.throttle;
									n_err[E_CLAMP] = 1'b0;
								end
								if (!it.driver_ok) begin
									n_mode = MODE_ERROR;
									n_err[E_PWM] = 1'b1;
									n_applied = 16'd0;
								end
							end
						end
					end
				end
			end
			als_pkg::CMD_TICK: begin
				if (link_q && (elapsed >= {16'd0, link_timeout_ms})) begin
					n_link = 1'b0;
					n_applied = 16'd0;
					n_need = 1'b1;
					if (mode_q != MODE_ERROR) begin
						n_mode = MODE_FAILSAFE;
					end
					n_err[E_LINK] = 1'b1;
					n_err[E_FS] = 1'b1;
				end
			end
			als_pkg::CMD_CRC: begin
				n_err[E_CRC] = 1'b1;
			end
			als_pkg::CMD_MALFORMED: begin
				n_err[E_INV] = 1'b1;
			end
		endcase
		res.mode = n_mode;
		res.error_bits = n_err;
		res.applied_level = n_applied;
		res.requested_level = n_requested;
		res.outputs_active = (n_mode == MODE_ARMED) && (n_applied != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DISARMED;
			err_q <= '0;
			sess_q <= '0;
			sess_known_q <= 1'b0;
			seq_q <= '0;
			seq_known_q <= 1'b0;
			need_q <= 1'b0;
			lvt_q <= '0;
			link_q <= 1'b0;
			applied_q <= '0;
			requested_q <= '0;
			sel_q <= '0;
		end else if (deq) begin
			mode_q <= n_mode;
			err_q <= n_err;
			sess_q <= n_sess;
			sess_known_q <= n_sess_known;
			seq_q <= n_seq;
			seq_known_q <= n_seq_known;
			need_q <= n_need;
			lvt_q <= n_lvt;
			link_q <= n_link;
			applied_q <= n_applied;
			requested_q <= n_requested;
			sel_q <= n_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (deq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({deq, pop_ok})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign empty = (cnt_q == 2'd0);
	assign out_item = mem_q[rd_ptr_q];

	a_active_armed: assert property (@(posedge clk) disable iff (!arst_n)
		deq && res.outputs_active |-> res.mode == MODE_ARMED)
		else $error("outputs active outside armed mode");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ERROR |=> mode_q == MODE_ERROR)
		else $error("error mode left without reset");

	a_applied_armed: assert property (@(posedge clk) disable iff (!arst_n)
		applied_q != 16'd0 |-> mode_q == MODE_ARMED)
		else $error("nonzero applied level outside armed mode");

	a_out_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

endmodule

/* sv/arming_link_supervisor.sv */
// top level of the arming link supervisor: configuration registers and the two halves
//
// usage
//  - input channel: drive in_item and raise push; a transfer happens on a clock edge
//    with push high and full low. one item may follow another in every cycle
//  - result channel: while empty is low the oldest result sits on out_item; a transfer
//    happens on a clock edge with pop high and empty low. every input item yields
//    exactly one result, in order
//  - configuration: cfg_valid with cfg_index/cfg_data; cfg_ready is always high.
//    index 0 max_throttle, 1 select_max, 2 link_timeout_ms, index 3 is ignored.
//    write only while the block holds no pending item
//  - path: after its input transfer an item waits in the front queue; the back end
//    moves the head item into the result queue whenever that queue has room;
//    throughput is one item per cycle while the result queue has room, set by the
//    combinational state update in the back end
//  - stall: a two-entry result queue and a two-entry front queue absorb a stalled
//    receiver; once both fill, full rises and no further item is taken
//  - reset: arst_n clears mode to disarmed, errors and all link/session state, empties
//    both queues and loads the configuration defaults 1000, 5 and 250
module arming_link_supervisor (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input als_pkg::in_item_t in_item,
	output logic empty,
	input logic pop,
	output als_pkg::out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [als_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [als_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [15:0] max_throttle_q;
	logic [7:0] select_max_q;
	logic [15:0] link_timeout_q;
	als_pkg::front_out_t front_out;
	logic deq;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_throttle_q <= als_pkg::MAX_THROTTLE_RST;
			select_max_q <= als_pkg::SELECT_MAX_RST;
			link_timeout_q <= als_pkg::LINK_TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				als_pkg::CFG_MAX_THROTTLE: max_throttle_q <= cfg_data;
				als_pkg::CFG_SELECT_MAX: select_max_q <= cfg_data[7:0];
				als_pkg::CFG_LINK_TIMEOUT: link_timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: input transfer, packet classification, short queue
	als_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.max_throttle(max_throttle_q),
		.select_max(select_max_q),
		.deq(deq),
		.front_out(front_out)
	);

	// back: mode/session/link state update and result queue
	als_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.front_out(front_out),
		.deq(deq),
		.max_throttle(max_throttle_q),
		.link_timeout_ms(link_timeout_q),
		.empty(empty),
		.pop(pop),
		.out_item(out_item)
	);

endmodule
